// ===== rtl/qcm_pkg.sv =====
`default_nettype none

package qcm_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_BITS      = 48;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int TABLE_SIZE   = 1 << TABLE_ADDR_BITS;
    localparam int TRIG_BITS    = 16;   // Q1.15 table magnitude
    localparam int FRAC_BITS    = 15;
    localparam int RATE_BITS    = 48;
    localparam int OFFSET_BITS  = 32;
    localparam int INDEX_BITS   = 32;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CHIRP_RATE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_OFFSET = CFG_INDEX_BITS'(1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
        logic                          last_in;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
        logic                          last_out;
    } result_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_MUL1,
        SEQ_MUL2
    } seq_state_t;

    typedef logic [TRIG_BITS-1:0] sine_rom_t [TABLE_SIZE];

    // Quarter-wave entry k: sin(pi*(2k+1)/(4N)) via Q30 Taylor series
    function automatic logic [TRIG_BITS-1:0] sine_entry(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (TABLE_ADDR_BITS + 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
        sum = (sum + 64'd16384) >> 15;
        if (sum > 64'd32767)
        begin
            sum = 64'd32767;
        end
        return sum[TRIG_BITS-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/quadratic_chirp_mixer_core.sv =====
// Pipeline: a request passes stage A, stage B, stage C and the result register.
// Throughput: one request per cycle outside the start-value rebuild; result_ready low stalls the whole pipe.
// After each configuration write the slice-start phase and step are rebuilt by
// a shift-add multiplier (two 32-step passes), during which sample_ready is low.
// Reset (rst_n low, async): registers, phase, index and valids cleared; the
// sine table is constant ROM and needs no loading.
`default_nettype none

module quadratic_chirp_mixer_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    sample_valid,
    output logic                                         sample_ready,
    input  wire qcm_pkg::sample_t                        sample,
    output logic                                         result_valid,
    input  wire logic                                    result_ready,
    output qcm_pkg::result_t                             result,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [qcm_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [qcm_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int PB    = qcm_pkg::PHASE_BITS;
    localparam int SB    = qcm_pkg::SAMPLE_BITS;
    localparam int AB    = qcm_pkg::TABLE_ADDR_BITS;
    localparam int TB    = qcm_pkg::TRIG_BITS;
    localparam int OB    = qcm_pkg::OFFSET_BITS;
    localparam int CNT_BITS  = $clog2(OB);
    localparam int PROD_BITS = SB + TB + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int FRAC_SHIFT = qcm_pkg::FRAC_BITS;

    localparam qcm_pkg::sine_rom_t SINE_ROM = qcm_pkg::build_sine_rom();

    // Configuration registers
    logic [qcm_pkg::RATE_BITS-1:0] chirp_rate_reg;
    logic [OB-1:0]                 bin_offset_reg;
    logic [PB-1:0]                 rate_ext;

    assign rate_ext = PB'(signed'(chirp_rate_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chirp_rate_reg <= '0;
            bin_offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qcm_pkg::REG_CHIRP_RATE: chirp_rate_reg <= cfg_data[qcm_pkg::RATE_BITS-1:0];
                qcm_pkg::REG_BIN_OFFSET: bin_offset_reg <= cfg_data[OB-1:0];
                default: ;
            endcase
        end
    end

    // Start-value sequencer: t = rate*m, acc0 = -t*m, step0 = -(2t + rate)
    qcm_pkg::seq_state_t state_reg, state_next;
    logic [PB-1:0]       mul_a_reg, mul_a_next;
    logic [OB-1:0]       mul_b_reg, mul_b_next;
    logic [PB-1:0]       prod_reg, prod_next;
    logic [PB-1:0]       t_reg, t_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PB-1:0]       start_acc_reg, start_acc_next;
    logic [PB-1:0]       start_step_reg, start_step_next;
    logic [PB-1:0]       prod_sum;

    assign prod_sum = prod_reg + (mul_b_reg[0] ? mul_a_reg : '0);

    always_comb
    begin
        state_next      = state_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        prod_next       = prod_reg;
        t_next          = t_reg;
        cnt_next        = cnt_reg;
        start_acc_next  = start_acc_reg;
        start_step_next = start_step_reg;
        unique case (state_reg)
            qcm_pkg::SEQ_IDLE:
            begin
            end
            qcm_pkg::SEQ_LOAD:
            begin
                mul_a_next = rate_ext;
                mul_b_next = bin_offset_reg;
                prod_next  = '0;
                cnt_next   = '0;
                state_next = qcm_pkg::SEQ_MUL1;
            end
            qcm_pkg::SEQ_MUL1:
            begin
                mul_a_next = mul_a_reg << 1;
                mul_b_next = mul_b_reg >> 1;
                prod_next  = prod_sum;
                cnt_next   = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(OB - 1))
                begin
                    t_next     = prod_sum;
                    mul_a_next = prod_sum;
                    mul_b_next = bin_offset_reg;
                    prod_next  = '0;
                    state_next = qcm_pkg::SEQ_MUL2;
                end
            end
            qcm_pkg::SEQ_MUL2:
            begin
                mul_a_next = mul_a_reg << 1;
                mul_b_next = mul_b_reg >> 1;
                prod_next  = prod_sum;
                cnt_next   = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(OB - 1))
                begin
                    start_acc_next  = '0 - prod_sum;
                    start_step_next = '0 - ((t_reg << 1) + rate_ext);
                    state_next      = qcm_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = qcm_pkg::SEQ_IDLE;
            end
        endcase
        // any write restarts the rebuild from the new register values
        if (cfg_wr_en)
        begin
            state_next = qcm_pkg::SEQ_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qcm_pkg::SEQ_IDLE;
            start_acc_reg  <= '0;
            start_step_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_acc_reg  <= start_acc_next;
            start_step_reg <= start_step_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= prod_next;
        t_reg     <= t_next;
    end

    // Pipeline control
    logic advance;
    logic accept;

    assign advance      = !result_valid || result_ready;
    assign sample_ready = advance && (state_reg == qcm_pkg::SEQ_IDLE);
    assign accept       = sample_valid && sample_ready;

    // Phase recurrence
    logic [qcm_pkg::INDEX_BITS-1:0] index_reg;
    logic [PB-1:0]                  acc_reg;
    logic [PB-1:0]                  step_reg;
    logic [PB-1:0]                  phase_cur;
    logic [PB-1:0]                  step_cur;
    logic                           slice_start;

    assign slice_start = (index_reg == '0);
    assign phase_cur   = slice_start ? start_acc_reg : acc_reg;
    assign step_cur    = slice_start ? start_step_reg : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            acc_reg   <= '0;
            step_reg  <= '0;
        end
        else if (accept)
        begin
            index_reg <= sample.last_in ? '0 : index_reg + qcm_pkg::INDEX_BITS'(1);
            acc_reg   <= phase_cur + step_cur;
            step_reg  <= step_cur - (rate_ext << 1);
        end
    end

    // Stage A: samples and quadrant/address
    logic                 a_valid_reg;
    qcm_pkg::sample_t     a_sample_reg;
    logic [1:0]           a_quad_reg;
    logic [AB-1:0]        a_addr_reg;

    // Stage B: table read
    logic                 b_valid_reg;
    qcm_pkg::sample_t     b_sample_reg;
    logic [TB-1:0]        b_sin_mag_reg;
    logic [TB-1:0]        b_cos_mag_reg;
    logic                 b_sin_neg_reg;
    logic                 b_cos_neg_reg;

    // Stage C: products
    logic                       c_valid_reg;
    logic                       c_last_reg;
    logic signed [PROD_BITS-1:0] c_ic_reg;
    logic signed [PROD_BITS-1:0] c_qs_reg;
    logic signed [PROD_BITS-1:0] c_is_reg;
    logic signed [PROD_BITS-1:0] c_qc_reg;

    logic                 res_valid_reg;
    qcm_pkg::result_t     res_reg;

    logic [AB-1:0]        sin_addr;
    logic [AB-1:0]        cos_addr;
    logic signed [TB:0]   sin_val;
    logic signed [TB:0]   cos_val;
    logic signed [SUM_BITS-1:0] sum_i;
    logic signed [SUM_BITS-1:0] sum_q;

    // odd quadrants read the sine mirrored, even ones the cosine (N-1-a == ~a)
    assign sin_addr = a_quad_reg[0] ? ~a_addr_reg : a_addr_reg;
    assign cos_addr = a_quad_reg[0] ? a_addr_reg : ~a_addr_reg;

    assign sin_val = b_sin_neg_reg ? -signed'({1'b0, b_sin_mag_reg})
                                   : signed'({1'b0, b_sin_mag_reg});
    assign cos_val = b_cos_neg_reg ? -signed'({1'b0, b_cos_mag_reg})
                                   : signed'({1'b0, b_cos_mag_reg});

    assign sum_i = SUM_BITS'(c_ic_reg) - SUM_BITS'(c_qs_reg);
    assign sum_q = SUM_BITS'(c_is_reg) + SUM_BITS'(c_qc_reg);

    function automatic logic signed [SB-1:0] round_sat(logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] r;
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'((64'sd1 <<< (SB - 1)) - 64'sd1);
        lo = -hi - SUM_BITS'(1);
        r  = (v + SUM_BITS'(1 << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (r > hi)
        begin
            r = hi;
        end
        else if (r < lo)
        begin
            r = lo;
        end
        return r[SB-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            res_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_sample_reg <= sample;
            a_quad_reg   <= phase_cur[PB-1 -: 2];
            a_addr_reg   <= phase_cur[PB-3 -: AB];

            b_sample_reg  <= a_sample_reg;
            b_sin_mag_reg <= SINE_ROM[sin_addr];
            b_cos_mag_reg <= SINE_ROM[cos_addr];
            b_sin_neg_reg <= a_quad_reg[1];
            b_cos_neg_reg <= a_quad_reg[1] ^ a_quad_reg[0];

            c_last_reg <= b_sample_reg.last_in;
            c_ic_reg   <= PROD_BITS'(b_sample_reg.sample_i * cos_val);
            c_qs_reg   <= PROD_BITS'(b_sample_reg.sample_q * sin_val);
            c_is_reg   <= PROD_BITS'(b_sample_reg.sample_i * sin_val);
            c_qc_reg   <= PROD_BITS'(b_sample_reg.sample_q * cos_val);

            res_reg.out_i    <= round_sat(sum_i);
            res_reg.out_q    <= round_sat(sum_q);
            res_reg.last_out <= c_last_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_LEN  = 1024;
    localparam logic [63:0] PI_Q30_TB  = 64'd3373259426;
    localparam logic [1:0]  REG_SPARE2 = 2'd2;
    localparam logic [1:0]  REG_SPARE3 = 2'd3;

    localparam logic [47:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] RATE_MIN = 48'h8000_0000_0000;
    // -3/32 turn per squared bin: walks all four quadrants and hits 135 degrees
    localparam logic [47:0] RATE_QUAD_WALK = 48'hE800_0000_0000;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    qcm_pkg::sample_t  sample_bus;
    logic              result_valid;
    logic              result_ready = 1'b0;
    qcm_pkg::result_t  result_bus;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [47:0]       cfg_data;

    // mixer model state
    logic [15:0] quarter_sine [TABLE_LEN];
    logic [47:0] chirp_rate_q;
    logic [31:0] bin_offset_q;
    logic [31:0] slice_index;
    logic [47:0] phase_acc;
    logic [47:0] phase_inc;

    qcm_pkg::result_t expected_mixed [$];
    int      failures = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      stall_cycles_left = 0;

    quadratic_chirp_mixer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Q30 Taylor series of sin at the center of quarter-wave bin k
    function automatic logic [15:0] quarter_sine_entry(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int unsigned n;
        x    = (PI_Q30_TB * (64'(k) * 64'd2 + 64'd1)) / 64'(4 * TABLE_LEN);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (n = 1; n < 19; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
            if (((n + 1) / 2) % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
            acc = 64'd32767;
        return acc[15:0];
    endfunction

    function automatic longint sine_lookup(logic [1:0] quad, logic [9:0] addr);
        logic [9:0] a;
        longint     v;
        a = quad[0] ? (10'(TABLE_LEN - 1) - addr) : addr;
        v = longint'({48'd0, quarter_sine[a]});
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [15:0] round_saturate(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    function automatic qcm_pkg::result_t dechirp_sample(qcm_pkg::sample_t s);
        logic [63:0] rate64;
        logic [63:0] m;
        logic [1:0]  quad;
        longint      sv;
        longint      cv;
        longint      si;
        longint      sq;
        qcm_pkg::result_t r;
        rate64 = {{16{chirp_rate_q[47]}}, chirp_rate_q};
        if (slice_index == 32'd0)
        begin
            m         = 64'(bin_offset_q);
            phase_acc = 48'(64'd0 - rate64 * m * m);
            phase_inc = 48'(64'd0 - rate64 * (64'd2 * m + 64'd1));
        end
        quad = phase_acc[47:46];
        sv   = sine_lookup(quad, phase_acc[45:36]);
        cv   = sine_lookup(quad + 2'd1, phase_acc[45:36]);
        si   = longint'(s.sample_i);
        sq   = longint'(s.sample_q);
        r.out_i    = round_saturate(si * cv - sq * sv);
        r.out_q    = round_saturate(si * sv + sq * cv);
        r.last_out = s.last_in;
        phase_acc   = phase_acc + phase_inc;
        phase_inc   = phase_inc - 48'(64'd2 * rate64);
        slice_index = s.last_in ? 32'd0 : slice_index + 32'd1;
        return r;
    endfunction

    function automatic qcm_pkg::sample_t make_sample(int i, int q, logic last);
        qcm_pkg::sample_t s;
        s.sample_i = 16'(i);
        s.sample_q = 16'(q);
        s.last_in  = last;
        return s;
    endfunction

    function automatic qcm_pkg::sample_t random_sample(logic last);
        qcm_pkg::sample_t s;
        case ($urandom_range(9))
            0: s.sample_i = 16'sh8000;
            1: s.sample_i = 16'sh7FFF;
            2: s.sample_i = 16'sh0000;
            default: s.sample_i = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0: s.sample_q = 16'sh8000;
            1: s.sample_q = 16'sh7FFF;
            2: s.sample_q = 16'sh0000;
            default: s.sample_q = 16'($urandom);
        endcase
        s.last_in = last;
        return s;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (stall_cycles_left > 0)
        begin
            result_ready <= 1'b0;
            stall_cycles_left--;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        qcm_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_mixed.size() == 0)
            begin
                $error("unexpected result: out_i=%0d out_q=%0d last_out=%0b",
                       result_bus.out_i, result_bus.out_q, result_bus.last_out);
                failures++;
            end
            else
            begin
                want = expected_mixed.pop_front();
                if (result_bus.out_i !== want.out_i)
                begin
                    $error("out_i: expected %0d, got %0d", want.out_i, result_bus.out_i);
                    failures++;
                end
                if (result_bus.out_q !== want.out_q)
                begin
                    $error("out_q: expected %0d, got %0d", want.out_q, result_bus.out_q);
                    failures++;
                end
                if (result_bus.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0b, got %0b",
                           want.last_out, result_bus.last_out);
                    failures++;
                end
            end
        end
    end

    task automatic send_sample(qcm_pkg::sample_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample_bus   = s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        expected_mixed.push_back(dechirp_sample(s));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (expected_mixed.size() != 0)
            @(posedge clk);
    endtask

    // only while idle; waits out the start-phase rebuild
    task automatic write_register(logic [1:0] idx, logic [47:0] data);
        int n;
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        case (idx)
            qcm_pkg::REG_CHIRP_RATE: chirp_rate_q = data;
            qcm_pkg::REG_BIN_OFFSET: bin_offset_q = data[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
        for (n = 0; n < 8 && sample_ready; n++)
            @(negedge clk);
        while (!sample_ready)
            @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic randomize_config();
        logic [47:0] rate;
        logic [31:0] offset;
        case ($urandom_range(5))
            0: rate = RATE_MAX;
            1: rate = RATE_MIN;
            2: rate = 48'd0;
            3: rate = 48'(longint'($urandom_range(1 << 25)) - longint'(1 << 24));
            default: rate = {16'($urandom), 32'($urandom)};
        endcase
        case ($urandom_range(4))
            0: offset = 32'd0;
            1: offset = 32'hFFFF_FFFF;
            2: offset = 32'($urandom_range(1000));
            default: offset = $urandom;
        endcase
        write_register(qcm_pkg::REG_CHIRP_RATE, rate);
        write_register(qcm_pkg::REG_BIN_OFFSET, {16'($urandom), offset});
    endtask

    // one slice; sometimes the rate is rewritten partway through
    task automatic send_slice(int len);
        int cut;
        int n;
        cut = ($urandom_range(3) == 0 && len > 1) ? $urandom_range(len - 1, 1) : 0;
        for (n = 0; n < len; n++)
        begin
            if (cut != 0 && n == cut)
            begin
                wait_drained();
                write_register(qcm_pkg::REG_CHIRP_RATE, {16'($urandom), 32'($urandom)});
            end
            send_sample(random_sample(n == len - 1));
        end
    endtask

    task automatic test_reset_state();
        send_sample(make_sample(32767, -32768, 1'b0));
        send_sample(make_sample(-32768, 32767, 1'b0));
        send_sample(make_sample(-1, 0, 1'b1));
        wait_drained();
    endtask

    task automatic test_quadrants_saturation();
        int n;
        write_register(qcm_pkg::REG_CHIRP_RATE, RATE_QUAD_WALK);
        write_register(qcm_pkg::REG_BIN_OFFSET, 48'd0);
        for (n = 0; n < 8; n++)
        begin
            case (n % 4)
                0: send_sample(make_sample(32767, 32767, n == 7));
                1: send_sample(make_sample(-32768, -32768, n == 7));
                2: send_sample(make_sample(32767, -32768, n == 7));
                default: send_sample(make_sample(-32768, 32767, n == 7));
            endcase
        end
        wait_drained();
    endtask

    task automatic test_config_extremes();
        int n;
        write_register(qcm_pkg::REG_CHIRP_RATE, RATE_MAX);
        write_register(qcm_pkg::REG_BIN_OFFSET, {16'hFFFF, 32'hFFFF_FFFF});
        for (n = 0; n < 3; n++)
            send_sample(random_sample(n == 2));
        wait_drained();
        write_register(qcm_pkg::REG_CHIRP_RATE, RATE_MIN);
        write_register(qcm_pkg::REG_BIN_OFFSET, 48'd0);
        for (n = 0; n < 3; n++)
            send_sample(random_sample(n == 2));
        wait_drained();
    endtask

    task automatic test_mid_slice_write();
        int n;
        write_register(qcm_pkg::REG_CHIRP_RATE, 48'h0000_1234_5678);
        write_register(qcm_pkg::REG_BIN_OFFSET, 48'd17);
        for (n = 0; n < 3; n++)
            send_sample(random_sample(1'b0));
        wait_drained();
        // new rate bends the running slice; new offset waits for the next one
        write_register(qcm_pkg::REG_CHIRP_RATE, 48'hFFFF_FFFF_FFFF);
        write_register(qcm_pkg::REG_BIN_OFFSET, 48'd5);
        for (n = 0; n < 4; n++)
            send_sample(random_sample(n == 1 || n == 3));
        wait_drained();
    endtask

    task automatic test_unused_registers();
        write_register(REG_SPARE2, {16'($urandom), 32'($urandom)});
        write_register(REG_SPARE3, {16'($urandom), 32'($urandom)});
        send_sample(random_sample(1'b0));
        send_sample(random_sample(1'b1));
        wait_drained();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
        int stop;
        wait_drained();
        set_idling(send_pct, recv_pct);
        randomize_config();
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            send_slice(($urandom_range(3) == 0) ? $urandom_range(4, 1) : $urandom_range(48, 1));
            if ($urandom_range(3) == 0)
            begin
                wait_drained();
                randomize_config();
            end
        end
        wait_drained();
    endtask

    // receiver blocked long enough for the pipe to fill and stall the sender
    task automatic test_stalled_receiver();
        int n;
        wait_drained();
        set_idling(0, 0);
        stall_cycles_left = 250;
        for (n = 0; n < 48; n++)
            send_sample(random_sample(n == 47));
        wait_drained();
    endtask

    initial
    begin
        int k;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_bus   = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        chirp_rate_q = '0;
        bin_offset_q = '0;
        slice_index  = '0;
        phase_acc    = '0;
        phase_inc    = '0;
        for (k = 0; k < TABLE_LEN; k++)
            quarter_sine[k] = quarter_sine_entry(k);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_quadrants_saturation();
        test_config_extremes();
        test_mid_slice_write();
        test_unused_registers();
        test_random_traffic(0, 0, 130);
        test_random_traffic(52, 0, 130);
        test_random_traffic(0, 52, 130);
        test_random_traffic(30, 30, 130);
        test_stalled_receiver();

        wait_drained();
        repeat (16) @(posedge clk);
        if (failures == 0 && expected_mixed.size() == 0)
        begin
            $display("quadratic_chirp_mixer_core: match");
        end
        else
        begin
            $display("quadratic_chirp_mixer_core: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("quadratic_chirp_mixer_core: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qcm_pkg.sv
rtl/quadratic_chirp_mixer_core.sv
sim/testbench.sv
